// File: rtl/assert_macros.svh
// assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define STIDR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication checked in the cycle after the trigger
`define STIDR_ASSERT_NEXT(lbl, clk, rst, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);

`endif

// File: rtl/stidr_pkg.sv
// shared types and constants for the sorted table unit
`default_nettype none

package stidr_pkg;

  // default sizes
  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // operation codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_RANK = 2'd2
  } status_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_INS_CHK,
    S_INS_CMP,
    S_DEL_RD,
    S_DEL_GET,
    S_DEL_CHK,
    S_DEL_MOV,
    S_RD_RD,
    S_RD_GET
  } state_t;

  // position counter updates
  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_TOP,
    CUR_RANK,
    CUR_INC,
    CUR_DEC
  } cur_op_t;

  // read address choice relative to the position counter
  typedef enum logic [1:0] {
    RD_CUR,
    RD_DN,
    RD_UP
  } rd_sel_t;

  // write data choice
  typedef enum logic {
    WR_VAL,
    WR_RDATA
  } wr_src_t;

  // entry count updates
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  // commands from controller to datapath
  typedef struct packed {
    cur_op_t cur_op;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_src_t wr_src;
    logic    res_cap;
    logic    fin;
    status_t fin_status;
    cnt_op_t cnt_op;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    op_t  op;
    logic full;
    logic rank_bad;
    logic cur_zero;
    logic ge;
    logic last;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/stidr_ctrl.sv
// controller state machine for the sorted table unit
`default_nettype none

module stidr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire stidr_pkg::sts_t   sts,
  output stidr_pkg::cmd_t        cmd,
  output logic                   busy
);

  stidr_pkg::state_t state;
  stidr_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stidr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      stidr_pkg::S_IDLE: begin
        if (accept) state_next = stidr_pkg::S_CHECK;
      end
      stidr_pkg::S_CHECK: begin
        unique case (sts.op)
          stidr_pkg::OP_INSERT: begin
            state_next = sts.full ? stidr_pkg::S_IDLE : stidr_pkg::S_INS_CHK;
          end
          stidr_pkg::OP_DELETE: begin
            state_next = sts.rank_bad ? stidr_pkg::S_IDLE : stidr_pkg::S_DEL_RD;
          end
          stidr_pkg::OP_READ: begin
            state_next = sts.rank_bad ? stidr_pkg::S_IDLE : stidr_pkg::S_RD_RD;
          end
          default: begin
            state_next = stidr_pkg::S_IDLE;
          end
        endcase
      end
      stidr_pkg::S_INS_CHK: begin
        state_next = sts.cur_zero ? stidr_pkg::S_IDLE : stidr_pkg::S_INS_CMP;
      end
      stidr_pkg::S_INS_CMP: begin
        state_next = sts.ge ? stidr_pkg::S_INS_CHK : stidr_pkg::S_IDLE;
      end
      stidr_pkg::S_DEL_RD:  state_next = stidr_pkg::S_DEL_GET;
      stidr_pkg::S_DEL_GET: state_next = stidr_pkg::S_DEL_CHK;
      stidr_pkg::S_DEL_CHK: begin
        state_next = sts.last ? stidr_pkg::S_IDLE : stidr_pkg::S_DEL_MOV;
      end
      stidr_pkg::S_DEL_MOV: state_next = stidr_pkg::S_DEL_CHK;
      stidr_pkg::S_RD_RD:   state_next = stidr_pkg::S_RD_GET;
      stidr_pkg::S_RD_GET:  state_next = stidr_pkg::S_IDLE;
      default:              state_next = stidr_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd            = '0;
    cmd.cur_op     = stidr_pkg::CUR_HOLD;
    cmd.rd_sel     = stidr_pkg::RD_CUR;
    cmd.wr_src     = stidr_pkg::WR_VAL;
    cmd.fin_status = stidr_pkg::ST_OK;
    cmd.cnt_op     = stidr_pkg::CNT_HOLD;
    unique case (state)
      stidr_pkg::S_IDLE: begin
      end
      stidr_pkg::S_CHECK: begin
        unique case (sts.op)
          stidr_pkg::OP_INSERT: begin
            if (sts.full) begin
              cmd.fin        = 1'b1;
              cmd.fin_status = stidr_pkg::ST_FULL;
            end else begin
              cmd.cur_op = stidr_pkg::CUR_TOP;
            end
          end
          stidr_pkg::OP_DELETE, stidr_pkg::OP_READ: begin
            if (sts.rank_bad) begin
              cmd.fin        = 1'b1;
              cmd.fin_status = stidr_pkg::ST_RANK;
            end else begin
              cmd.cur_op = stidr_pkg::CUR_RANK;
            end
          end
          default: begin
            cmd.fin = 1'b1;
          end
        endcase
      end
      // walk down from the top, moving larger-or-equal entries up by one
      stidr_pkg::S_INS_CHK: begin
        if (sts.cur_zero) begin
          cmd.wr_en  = 1'b1;
          cmd.fin    = 1'b1;
          cmd.cnt_op = stidr_pkg::CNT_INC;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = stidr_pkg::RD_DN;
        end
      end
      stidr_pkg::S_INS_CMP: begin
        cmd.wr_en = 1'b1;
        if (sts.ge) begin
          cmd.wr_src = stidr_pkg::WR_RDATA;
          cmd.cur_op = stidr_pkg::CUR_DEC;
        end else begin
          cmd.fin    = 1'b1;
          cmd.cnt_op = stidr_pkg::CNT_INC;
        end
      end
      stidr_pkg::S_DEL_RD: begin
        cmd.rd_en = 1'b1;
      end
      stidr_pkg::S_DEL_GET: begin
        cmd.res_cap = 1'b1;
      end
      // close the gap one entry at a time
      stidr_pkg::S_DEL_CHK: begin
        if (sts.last) begin
          cmd.fin    = 1'b1;
          cmd.cnt_op = stidr_pkg::CNT_DEC;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = stidr_pkg::RD_UP;
        end
      end
      stidr_pkg::S_DEL_MOV: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = stidr_pkg::WR_RDATA;
        cmd.cur_op = stidr_pkg::CUR_INC;
      end
      stidr_pkg::S_RD_RD: begin
        cmd.rd_en = 1'b1;
      end
      stidr_pkg::S_RD_GET: begin
        cmd.res_cap = 1'b1;
        cmd.fin     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign busy = (state != stidr_pkg::S_IDLE);

endmodule

`default_nettype wire

// File: rtl/stidr_datapath.sv
// datapath of the sorted table unit: value memory, counters and result registers
`default_nettype none

module stidr_datapath #(
  parameter  int CAPACITY    = stidr_pkg::CAPACITY_DEF,
  parameter  int VALUE_WIDTH = stidr_pkg::VALUE_WIDTH_DEF,
  localparam int CNT_W       = $clog2(CAPACITY + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic [1:0]                    op,
  input  wire logic signed [VALUE_WIDTH-1:0] value,
  input  wire logic [CNT_W-1:0]              rank,
  input  wire stidr_pkg::cmd_t               cmd,
  output stidr_pkg::sts_t                    sts,
  output logic                               done,
  output logic signed [VALUE_WIDTH-1:0]      result_value,
  output logic [1:0]                         status,
  output logic [CNT_W-1:0]                   entry_count
);

  localparam int IDX_W = $clog2(CAPACITY);

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];

  stidr_pkg::op_t          op_r;
  logic [VALUE_WIDTH-1:0]  val_r;
  logic [CNT_W-1:0]        rank_r;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic [CNT_W-1:0]        cur;
  logic [CNT_W-1:0]        cur_dn;
  logic [CNT_W-1:0]        cur_up;
  logic [CNT_W-1:0]        rd_pos;
  logic [VALUE_WIDTH-1:0]  rdata;
  logic [VALUE_WIDTH-1:0]  res;
  logic [VALUE_WIDTH-1:0]  wr_data;

  assign cur_dn = cur - 1'b1;
  assign cur_up = cur + 1'b1;

  // operation capture on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= stidr_pkg::op_t'(op);
      val_r  <= value;
      rank_r <= rank;
    end
  end

  // position counter
  always_ff @(posedge clk) begin
    case (cmd.cur_op)
      stidr_pkg::CUR_TOP:  cur <= count;
      stidr_pkg::CUR_RANK: cur <= rank_r - 1'b1;
      stidr_pkg::CUR_INC:  cur <= cur_up;
      stidr_pkg::CUR_DEC:  cur <= cur_dn;
      default:             cur <= cur;
    endcase
  end

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      stidr_pkg::RD_DN: rd_pos = cur_dn;
      stidr_pkg::RD_UP: rd_pos = cur_up;
      default:          rd_pos = cur;
    endcase
  end

  assign wr_data = (cmd.wr_src == stidr_pkg::WR_RDATA) ? rdata : val_r;

  // value memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cur[IDX_W-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_pos[IDX_W-1:0]];
    end
  end

  // removed or read value, cleared for each new operation
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= '0;
    end else if (cmd.res_cap) begin
      res <= rdata;
    end
  end

  // entry count
  always_comb begin
    case (cmd.cnt_op)
      stidr_pkg::CNT_INC: count_next = count + 1'b1;
      stidr_pkg::CNT_DEC: count_next = count - 1'b1;
      default:            count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result registers and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      result_value <= cmd.res_cap ? rdata : res;
      status       <= cmd.fin_status;
      entry_count  <= count_next;
    end
  end

  // status toward the controller
  always_comb begin
    sts.op       = op_r;
    sts.full     = (count == CNT_W'(CAPACITY));
    sts.rank_bad = (rank_r == '0) || (rank_r > count);
    sts.cur_zero = (cur == '0);
    sts.ge       = ($signed(rdata) >= $signed(val_r));
    sts.last     = (cur_up >= count);
  end

endmodule

`default_nettype wire

// File: rtl/sorted_table_insert_delete_by_rank_unit.sv
// Sorted table of up to CAPACITY signed values with insert, delete by rank and read by rank.
// One operation at a time: start is taken while busy is low, and the result shows
// on result_value, status and entry_count for the single cycle in which done is high;
// the receiver cannot stall it, and busy is already low in that cycle. The table sits
// in a one-port-read memory, so every moved entry costs a read and a write.
// An insert moves every entry not smaller than the new value up by one; when every
// stored entry is not smaller, the value lands at the head. A delete moves every
// entry behind the removed one down by one, and a read moves nothing. An error or
// the unused op code ends the operation without touching the table.
`default_nettype none

module sorted_table_insert_delete_by_rank_unit #(
  parameter  int CAPACITY    = stidr_pkg::CAPACITY_DEF,
  parameter  int VALUE_WIDTH = stidr_pkg::VALUE_WIDTH_DEF,
  localparam int CNT_W       = $clog2(CAPACITY + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    op,
  input  wire logic signed [VALUE_WIDTH-1:0] value,
  input  wire logic [CNT_W-1:0]              rank,
  output logic                               done,
  output logic signed [VALUE_WIDTH-1:0]      result_value,
  output logic [1:0]                         status,
  output logic [CNT_W-1:0]                   entry_count
);

  stidr_pkg::cmd_t cmd;
  stidr_pkg::sts_t sts;
  logic            accept;

  assign accept = start && !busy;

  // controller
  stidr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  // datapath
  stidr_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .op           (op),
    .value        (value),
    .rank         (rank),
    .cmd          (cmd),
    .sts          (sts),
    .done         (done),
    .result_value (result_value),
    .status       (status),
    .entry_count  (entry_count)
  );

endmodule

`default_nettype wire

// File: rtl/stidr_checker.sv
// port-level checks for the sorted table unit, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module stidr_checker #(
  parameter  int CAPACITY    = stidr_pkg::CAPACITY_DEF,
  parameter  int VALUE_WIDTH = stidr_pkg::VALUE_WIDTH_DEF,
  localparam int CNT_W       = $clog2(CAPACITY + 1)
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic [1:0]                    op,
  input wire logic signed [VALUE_WIDTH-1:0] value,
  input wire logic [CNT_W-1:0]              rank,
  input wire logic                          done,
  input wire logic signed [VALUE_WIDTH-1:0] result_value,
  input wire logic [1:0]                    status,
  input wire logic [CNT_W-1:0]              entry_count
);

  // a transfer always makes the unit busy next cycle
  `STIDR_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "transfer did not raise busy")

  // the unit is free again while a result is shown
  `STIDR_ASSERT(a_done_idle, clk, rst, done |-> !busy, "done while busy")

  // status stays within its codes
  `STIDR_ASSERT(a_status_code, clk, rst, done |-> (status != 2'd3), "bad status code")

  // a full-table error reports a full count and no value
  `STIDR_ASSERT(a_full_count, clk, rst, (done && status == stidr_pkg::ST_FULL) |-> (entry_count == CNT_W'(CAPACITY) && result_value == '0), "full error with wrong count or value")

  // a rank error returns no value
  `STIDR_ASSERT(a_rank_zero, clk, rst, (done && status == stidr_pkg::ST_RANK) |-> (result_value == '0), "rank error with nonzero value")

endmodule

bind sorted_table_insert_delete_by_rank_unit stidr_checker #(
  .CAPACITY    (CAPACITY),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_stidr_checker (.*);

`default_nettype wire

// File: tb/sv/stidr_table_checker.sv
// checker for the sorted table unit: predicts each transfer and compares the results
module stidr_table_checker
  import stidr_pkg::*;
#(
  parameter int CAP = CAPACITY_DEF,
  parameter int VW  = VALUE_WIDTH_DEF,
  parameter int CW  = $clog2(CAP + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [1:0]           op,
  input  logic signed [VW-1:0] value,
  input  logic [CW-1:0]        rank,
  input  logic                 done,
  input  logic signed [VW-1:0] result_value,
  input  logic [1:0]           status,
  input  logic [CW-1:0]        entry_count,
  output int                   fail_count,
  output int                   pending
);

  // one expected result of a table operation
  typedef struct {
    logic signed [VW-1:0] val;
    status_t              st;
    logic [CW-1:0]        cnt;
  } table_result_t;

  // shadow copy of the sorted table
  logic signed [VW-1:0] shadow_tbl [CAP];
  int                   shadow_cnt;
  table_result_t        expected_q [$];
  int                   fails;

  initial begin
    fail_count = 0;
    pending    = 0;
    fails      = 0;
    shadow_cnt = 0;
  end

  // apply one operation to the shadow table and return its result
  function automatic table_result_t predict_table_op(op_t o, logic signed [VW-1:0] v,
                                                     logic [CW-1:0] r);
    table_result_t res;
    int            pos;
    int            i;
    res.val = '0;
    res.st  = ST_OK;
    case (o)
      OP_INSERT: begin
        if (shadow_cnt >= CAP) begin
          res.st = ST_FULL;
        end else begin
          // new value goes ahead of the first entry not smaller than it
          pos = 0;
          while (pos < shadow_cnt && shadow_tbl[pos] < v) pos++;
          for (i = shadow_cnt; i > pos; i--) shadow_tbl[i] = shadow_tbl[i-1];
          shadow_tbl[pos] = v;
          shadow_cnt++;
        end
      end
      OP_DELETE, OP_READ: begin
        if (r == 0 || r > shadow_cnt) begin
          res.st = ST_RANK;
        end else begin
          pos = r - 1;
          res.val = shadow_tbl[pos];
          if (o == OP_DELETE) begin
            for (i = pos; i + 1 < shadow_cnt; i++) shadow_tbl[i] = shadow_tbl[i+1];
            shadow_cnt--;
          end
        end
      end
      default: ;
    endcase
    res.cnt = shadow_cnt[CW-1:0];
    return res;
  endfunction

  // compare results first, then record the transfer of this edge
  always @(posedge clk) begin
    table_result_t want;
    if (rst) begin
      shadow_cnt = 0;
      expected_q.delete();
      pending <= 0;
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          $error("result with no transfer outstanding: value %0d status %0d count %0d",
                 result_value, status, entry_count);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (result_value !== want.val) begin
            $error("result_value: expected %0d, actual %0d", want.val, result_value);
            fails++;
          end
          if (status !== want.st) begin
            $error("status: expected %0d, actual %0d", want.st, status);
            fails++;
          end
          if (entry_count !== want.cnt) begin
            $error("entry_count: expected %0d, actual %0d", want.cnt, entry_count);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        expected_q.push_back(predict_table_op(op_t'(op), value, rank));
      end
      pending    <= expected_q.size();
      fail_count <= fails;
    end
  end

endmodule

// File: tb/sv/tb_sorted_table_insert_delete_by_rank_unit.sv
// testbench top for the sorted table unit: clock, reset, stimulus and verdict
module tb_sorted_table_insert_delete_by_rank_unit;
  import stidr_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int VW  = VALUE_WIDTH_DEF;
  localparam int CW  = $clog2(CAP + 1);

  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic [CW-1:0]        RANK_ALL = '1;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [1:0]           op = OP_NOP;
  logic signed [VW-1:0] value = '0;
  logic [CW-1:0]        rank = '0;
  logic                 busy;
  logic                 done;
  logic signed [VW-1:0] result_value;
  logic [1:0]           status;
  logic [CW-1:0]        entry_count;
  int                   fail_count;
  int                   pending;
  int                   seen_count = 0;

  sorted_table_insert_delete_by_rank_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .value        (value),
    .rank         (rank),
    .done         (done),
    .result_value (result_value),
    .status       (status),
    .entry_count  (entry_count)
  );

  stidr_table_checker #(.CAP(CAP), .VW(VW), .CW(CW)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .value        (value),
    .rank         (rank),
    .done         (done),
    .result_value (result_value),
    .status       (status),
    .entry_count  (entry_count),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // last count reported by the block, used to aim ranks at live entries
  always @(posedge clk) begin
    if (done) seen_count <= entry_count;
  end

  // one transfer, after a random number of idle cycles
  task automatic issue_op(input op_t o, input logic signed [VW-1:0] v,
                          input logic [CW-1:0] r, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    op    <= o;
    value <= v;
    rank  <= r;
    do @(posedge clk); while (busy);
  endtask

  // random field values, biased toward duplicates and live ranks
  function automatic logic signed [VW-1:0] pick_value();
    int k;
    k = $urandom_range(9);
    if (k < 6) return $urandom;
    if (k < 8) return $urandom_range(16) - 8;
    return ($urandom_range(1) != 0) ? VAL_MAX : VAL_MIN;
  endfunction

  function automatic logic [CW-1:0] pick_rank(int cnt);
    int k;
    k = $urandom_range(9);
    if (k < 8) return $urandom_range((cnt == 0) ? 1 : cnt, 1);
    if (k == 8) return ($urandom_range(1) != 0) ? '0 : cnt + 1;
    return $urandom_range(RANK_ALL);
  endfunction

  // stimulus
  initial begin
    int   idle_pct;
    int   r;
    bit   filling;
    op_t  o;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: errors on empty table, single-entry delete, extremes, equal to head
    issue_op(OP_READ,   '0, 1, 0);
    issue_op(OP_DELETE, '0, 0, 0);
    issue_op(OP_NOP,    '1, RANK_ALL, 0);
    issue_op(OP_INSERT, '0, 0, 0);
    issue_op(OP_DELETE, '0, 1, 0);
    issue_op(OP_INSERT, VAL_MAX, 0, 0);
    issue_op(OP_INSERT, VAL_MIN, 0, 0);
    issue_op(OP_INSERT, VAL_MIN, 0, 0);
    issue_op(OP_INSERT, -1, 0, 0);
    issue_op(OP_INSERT, 1, 0, 0);
    issue_op(OP_READ,   '0, 0, 0);
    issue_op(OP_READ,   '0, 1, 0);
    issue_op(OP_READ,   '0, 5, 0);
    issue_op(OP_READ,   '0, 6, 0);
    issue_op(OP_DELETE, '0, RANK_ALL, 0);
    issue_op(OP_DELETE, '0, 5, 0);
    issue_op(OP_DELETE, '0, 1, 0);
    issue_op(OP_NOP,    '0, 0, 0);
    issue_op(OP_INSERT, 32'h5555_5555, 0, 0);
    issue_op(OP_INSERT, 32'haaaa_aaaa, 0, 0);

    // random: alternate fill and drain blocks so the table reaches full and empty
    for (int blk = 0; blk < 8; blk++) begin
      filling = (blk % 2 == 0);
      case (blk % 3)
        0: idle_pct = 0;
        1: idle_pct = 51;
        default: idle_pct = 11;
      endcase
      for (int i = 0; i < 144; i++) begin
        r = $urandom_range(99);
        if (filling) begin
          o = (r < 68) ? OP_INSERT : (r < 78) ? OP_DELETE : (r < 95) ? OP_READ : OP_NOP;
        end else begin
          o = (r < 15) ? OP_INSERT : (r < 70) ? OP_DELETE : (r < 95) ? OP_READ : OP_NOP;
        end
        issue_op(o, pick_value(), pick_rank(seen_count), idle_pct);
      end
    end
    start <= 1'b0;
    @(posedge clk);

    // drain outstanding results, then let the block settle
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule
